// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bin to channel gather unit
// Clocked on clk, switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define BCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define BCG_NEVER(lbl, cond, msg) \
    `BCG_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/bcg_pkg.sv =====
// ---------------------------------------------------------------------------
// bcg_pkg
// Shared widths, codes, types and divide helpers for the gather unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcg_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = 12;
    localparam int IN_LANES   = 4;
    localparam int OUT_LANES  = 4;
    localparam int MAP_W      = 48;
    localparam int GRP_NUM_W  = 10;
    localparam int MAX_GRP_W  = 12;    // GROUPS is at most 4096
    localparam int DIV_W      = 13;    // holds any divisor up to 4096

    // Reciprocal divide: exact for 12-bit dividends and divisors up to 4096
    localparam int RECIP_SH   = 26;
    localparam int RECIP_W    = 27;

    // Result queue, power of two
    localparam int FIFO_DEPTH = 8;

    // Parameter defaults
    localparam int DEF_BINS_PER_CLOCK = 4;
    localparam int DEF_RES_PER_CLOCK  = 4;
    localparam int DEF_GROUPS         = 1024;

    typedef enum logic {
        ACT_BIN = 1'b0,
        ACT_MAP = 1'b1
    } action_t;

    // Memory clearing sweep after reset
    typedef struct packed {
        logic                 active;
        logic [MAX_GRP_W-1:0] addr;
    } clr_t;

    // Per-item control travelling down the pipeline
    typedef struct packed {
        logic                 valid;
        logic                 frame_end;
        logic [GRP_NUM_W-1:0] group_number;
    } meta_t;

    // Quotient of x by the divisor whose reciprocal is m
    function automatic logic [IDX_W-1:0] recip_quot(
        input logic [IDX_W-1:0]   x,
        input logic [RECIP_W-1:0] m
    );
        logic [IDX_W+RECIP_W-1:0] p;
        p = (IDX_W+RECIP_W)'(x) * (IDX_W+RECIP_W)'(m);
        return p[RECIP_SH +: IDX_W];
    endfunction

    // Remainder from a known quotient
    function automatic logic [IDX_W-1:0] quot_rem(
        input logic [IDX_W-1:0] x,
        input logic [IDX_W-1:0] q,
        input logic [DIV_W-1:0] d
    );
        logic [IDX_W+DIV_W-1:0] p;
        p = (IDX_W+DIV_W)'(q) * (IDX_W+DIV_W)'(d);
        return x - p[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/bcg_in_if.sv =====
// ---------------------------------------------------------------------------
// bcg_in_if
// Input channel: bin words and channel map writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcg_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [bcg_pkg::SAMPLE_W-1:0]   bin_iq_0;
    logic [bcg_pkg::SAMPLE_W-1:0]   bin_iq_1;
    logic [bcg_pkg::SAMPLE_W-1:0]   bin_iq_2;
    logic [bcg_pkg::SAMPLE_W-1:0]   bin_iq_3;
    logic                           frame_last;
    logic [bcg_pkg::GRP_NUM_W-1:0]  map_group;
    logic [bcg_pkg::MAP_W-1:0]      map_entry;

    modport source (
        output valid, action, bin_iq_0, bin_iq_1, bin_iq_2, bin_iq_3,
               frame_last, map_group, map_entry,
        input  ready
    );

    modport sink (
        input  valid, action, bin_iq_0, bin_iq_1, bin_iq_2, bin_iq_3,
               frame_last, map_group, map_entry,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/bcg_out_if.sv =====
// ---------------------------------------------------------------------------
// bcg_out_if
// Output channel: gathered channel samples with group tag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcg_out_if;
    logic                           valid;
    logic                           ready;
    logic [bcg_pkg::SAMPLE_W-1:0]   res_iq_0;
    logic [bcg_pkg::SAMPLE_W-1:0]   res_iq_1;
    logic [bcg_pkg::SAMPLE_W-1:0]   res_iq_2;
    logic [bcg_pkg::SAMPLE_W-1:0]   res_iq_3;
    logic                           frame_end;
    logic [bcg_pkg::GRP_NUM_W-1:0]  group_number;

    modport source (
        output valid, res_iq_0, res_iq_1, res_iq_2, res_iq_3,
               frame_end, group_number,
        input  ready
    );

    modport sink (
        input  valid, res_iq_0, res_iq_1, res_iq_2, res_iq_3,
               frame_end, group_number,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/bcg_map_stage.sv =====
// ---------------------------------------------------------------------------
// bcg_map_stage
// Takes items, keeps the replay and write counters and owns the channel
// map memory (map writes and replay reads both in the second stage).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcg_map_stage #(
    parameter int  BINS_PER_CLOCK = bcg_pkg::DEF_BINS_PER_CLOCK,
    parameter int  GROUPS         = bcg_pkg::DEF_GROUPS,
    localparam int STORE_LANES    = (BINS_PER_CLOCK < bcg_pkg::IN_LANES) ?
                                    BINS_PER_CLOCK : bcg_pkg::IN_LANES,
    localparam int GRP_W          = $clog2(GROUPS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    bcg_in_if.sink                                 in_ch,
    input  logic                                   accept_ok,
    input  bcg_pkg::clr_t                          clr,
    output logic                                   accept_bin,
    output bcg_pkg::meta_t                         p1_meta,
    output logic [bcg_pkg::SAMPLE_W*STORE_LANES-1:0] p1_iq,
    output logic [GRP_W-1:0]                       p1_slot,
    output logic [bcg_pkg::MAP_W-1:0]              map_rdata
);
    import bcg_pkg::*;

    localparam int IQ_W = SAMPLE_W * STORE_LANES;
    localparam logic [RECIP_W-1:0] G_RECIP =
        RECIP_W'((2**RECIP_SH + GROUPS - 1) / GROUPS);

    logic                    accept;
    logic [SAMPLE_W*IN_LANES-1:0] iq_all;
    logic                    last_grp;
    logic [IDX_W-1:0]        mg_ext;
    logic [GRP_W-1:0]        map_addr;

    logic [GRP_W-1:0]        replay_reg, replay_next;
    logic [GRP_W-1:0]        slot_reg, slot_next;

    meta_t                   p0_meta_reg;
    logic                    p0_map_valid_reg;
    logic [IQ_W-1:0]         p0_iq_reg;
    logic [GRP_W-1:0]        p0_slot_reg;
    logic [GRP_W-1:0]        p0_replay_reg;
    logic [IDX_W-1:0]        p0_mg_reg;
    logic [IDX_W-1:0]        p0_mq_reg;
    logic [MAP_W-1:0]        p0_entry_reg;

    meta_t                   p1_meta_reg;
    logic [IQ_W-1:0]         p1_iq_reg;
    logic [GRP_W-1:0]        p1_slot_reg;
    logic [MAP_W-1:0]        map_rdata_reg;

    logic [MAP_W-1:0]        map_mem [GROUPS];

    // Handshake
    assign in_ch.ready = accept_ok;
    assign accept      = in_ch.valid && accept_ok;
    assign accept_bin  = accept && (in_ch.action == ACT_BIN);

    assign iq_all = {in_ch.bin_iq_3, in_ch.bin_iq_2, in_ch.bin_iq_1, in_ch.bin_iq_0};
    assign mg_ext = IDX_W'(in_ch.map_group);

    // Counters, both modulo GROUPS
    always_comb
    begin
        last_grp    = (replay_reg == GRP_W'(GROUPS - 1));
        replay_next = replay_reg;
        slot_next   = slot_reg;
        if (accept_bin)
        begin
            replay_next = last_grp ? '0 : replay_reg + 1'b1;
            if (in_ch.frame_last)
                slot_next = '0;
            else if (slot_reg == GRP_W'(GROUPS - 1))
                slot_next = '0;
            else
                slot_next = slot_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replay_reg       <= '0;
            slot_reg         <= '0;
            p0_meta_reg      <= '0;
            p0_map_valid_reg <= 1'b0;
            p1_meta_reg      <= '0;
        end
        else
        begin
            replay_reg                <= replay_next;
            slot_reg                  <= slot_next;
            p0_meta_reg.valid         <= accept_bin;
            p0_meta_reg.frame_end     <= last_grp;
            p0_meta_reg.group_number  <= GRP_NUM_W'(replay_reg);
            p0_map_valid_reg          <= accept && (in_ch.action == ACT_MAP);
            p1_meta_reg               <= p0_meta_reg;
        end
    end

    // Stage 0 payload; map address quotient starts here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_iq_reg     <= iq_all[IQ_W-1:0];
            p0_slot_reg   <= slot_reg;
            p0_replay_reg <= replay_reg;
            p0_mg_reg     <= mg_ext;
            p0_mq_reg     <= recip_quot(mg_ext, G_RECIP);
            p0_entry_reg  <= in_ch.map_entry;
        end
        p1_iq_reg   <= p0_iq_reg;
        p1_slot_reg <= p0_slot_reg;
    end

    // map_group modulo GROUPS
    always_comb
    begin
        map_addr = GRP_W'(quot_rem(p0_mg_reg, p0_mq_reg, DIV_W'(GROUPS)));
    end

    // Channel map memory: writes and replay reads in one stage, read-first
    always_ff @(posedge clk)
    begin
        if (clr.active)
            map_mem[clr.addr[GRP_W-1:0]] <= '0;
        else if (p0_map_valid_reg)
            map_mem[map_addr] <= p0_entry_reg;
        map_rdata_reg <= map_mem[p0_replay_reg];
    end

    assign p1_meta   = p1_meta_reg;
    assign p1_iq     = p1_iq_reg;
    assign p1_slot   = p1_slot_reg;
    assign map_rdata = map_rdata_reg;

    // Checks
    `BCG_ASSERT(a_slot_frame_reset, accept_bin && in_ch.frame_last |=> slot_reg == '0, "write slot not reset after frame last")
    `BCG_ASSERT(a_replay_hold, !accept_bin |=> $stable(replay_reg), "replay counter moved without a bin item")

endmodule

`default_nettype wire

// ===== src/bcg_index_calc.sv =====
// ---------------------------------------------------------------------------
// bcg_index_calc
// Splits each 12-bit bin index of a map entry into cache word and lane,
// and carries the bin word alongside.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcg_index_calc #(
    parameter int  BINS_PER_CLOCK = bcg_pkg::DEF_BINS_PER_CLOCK,
    parameter int  RES_PER_CLOCK  = bcg_pkg::DEF_RES_PER_CLOCK,
    parameter int  GROUPS         = bcg_pkg::DEF_GROUPS,
    localparam int STORE_LANES    = (BINS_PER_CLOCK < bcg_pkg::IN_LANES) ?
                                    BINS_PER_CLOCK : bcg_pkg::IN_LANES,
    localparam int USE_LANES      = (RES_PER_CLOCK < bcg_pkg::OUT_LANES) ?
                                    RES_PER_CLOCK : bcg_pkg::OUT_LANES,
    localparam int LANE_W         = (BINS_PER_CLOCK > 1) ? $clog2(BINS_PER_CLOCK) : 1,
    localparam int GRP_W          = $clog2(GROUPS)
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  bcg_pkg::meta_t                              p1_meta,
    input  logic [bcg_pkg::SAMPLE_W*STORE_LANES-1:0]    p1_iq,
    input  logic [GRP_W-1:0]                            p1_slot,
    input  logic [bcg_pkg::MAP_W-1:0]                   map_rdata,
    output bcg_pkg::meta_t                              p3_meta,
    output logic [bcg_pkg::SAMPLE_W*STORE_LANES-1:0]    p3_iq,
    output logic [GRP_W-1:0]                            p3_slot,
    output logic [USE_LANES-1:0][bcg_pkg::IDX_W-1:0]    p3_q,
    output logic [USE_LANES-1:0][bcg_pkg::IDX_W-1:0]    p3_q2,
    output logic [USE_LANES-1:0][LANE_W-1:0]            p3_lane
);
    import bcg_pkg::*;

    localparam int IQ_W = SAMPLE_W * STORE_LANES;
    localparam logic [RECIP_W-1:0] B_RECIP =
        RECIP_W'((2**RECIP_SH + BINS_PER_CLOCK - 1) / BINS_PER_CLOCK);
    localparam logic [RECIP_W-1:0] G_RECIP =
        RECIP_W'((2**RECIP_SH + GROUPS - 1) / GROUPS);

    meta_t                             p2_meta_reg, p3_meta_reg;
    logic [IQ_W-1:0]                   p2_iq_reg, p3_iq_reg;
    logic [GRP_W-1:0]                  p2_slot_reg, p3_slot_reg;
    logic [USE_LANES-1:0][IDX_W-1:0]   p2_bin_reg;
    logic [USE_LANES-1:0][IDX_W-1:0]   p2_q_reg;
    logic [USE_LANES-1:0][IDX_W-1:0]   p3_q_reg;
    logic [USE_LANES-1:0][IDX_W-1:0]   p3_q2_reg;
    logic [USE_LANES-1:0][LANE_W-1:0]  p3_lane_reg;

    // Item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_meta_reg <= '0;
            p3_meta_reg <= '0;
        end
        else
        begin
            p2_meta_reg <= p1_meta;
            p3_meta_reg <= p2_meta_reg;
        end
    end

    // Stage 2: bin / BINS_PER_CLOCK; stage 3: lane and quotient / GROUPS
    always_ff @(posedge clk)
    begin
        p2_iq_reg   <= p1_iq;
        p2_slot_reg <= p1_slot;
        p3_iq_reg   <= p2_iq_reg;
        p3_slot_reg <= p2_slot_reg;
        for (int i = 0; i < USE_LANES; i++)
        begin
            p2_bin_reg[i]  <= map_rdata[i*IDX_W +: IDX_W];
            p2_q_reg[i]    <= recip_quot(map_rdata[i*IDX_W +: IDX_W], B_RECIP);
            p3_lane_reg[i] <= LANE_W'(quot_rem(p2_bin_reg[i], p2_q_reg[i],
                                               DIV_W'(BINS_PER_CLOCK)));
            p3_q_reg[i]    <= p2_q_reg[i];
            p3_q2_reg[i]   <= recip_quot(p2_q_reg[i], G_RECIP);
        end
    end

    assign p3_meta = p3_meta_reg;
    assign p3_iq   = p3_iq_reg;
    assign p3_slot = p3_slot_reg;
    assign p3_q    = p3_q_reg;
    assign p3_q2   = p3_q2_reg;
    assign p3_lane = p3_lane_reg;

endmodule

`default_nettype wire

// ===== src/bcg_cache.sv =====
// ---------------------------------------------------------------------------
// bcg_cache
// Bin cache, one copy per output lane so every lane has its own read port.
// The bin word is written in the same cycle as its own lookups; a match
// with the write slot is forwarded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcg_cache #(
    parameter int  BINS_PER_CLOCK = bcg_pkg::DEF_BINS_PER_CLOCK,
    parameter int  RES_PER_CLOCK  = bcg_pkg::DEF_RES_PER_CLOCK,
    parameter int  GROUPS         = bcg_pkg::DEF_GROUPS,
    localparam int STORE_LANES    = (BINS_PER_CLOCK < bcg_pkg::IN_LANES) ?
                                    BINS_PER_CLOCK : bcg_pkg::IN_LANES,
    localparam int USE_LANES      = (RES_PER_CLOCK < bcg_pkg::OUT_LANES) ?
                                    RES_PER_CLOCK : bcg_pkg::OUT_LANES,
    localparam int LANE_W         = (BINS_PER_CLOCK > 1) ? $clog2(BINS_PER_CLOCK) : 1,
    localparam int GRP_W          = $clog2(GROUPS)
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  bcg_pkg::clr_t                                 clr,
    input  bcg_pkg::meta_t                                p3_meta,
    input  logic [bcg_pkg::SAMPLE_W*STORE_LANES-1:0]      p3_iq,
    input  logic [GRP_W-1:0]                              p3_slot,
    input  logic [USE_LANES-1:0][bcg_pkg::IDX_W-1:0]      p3_q,
    input  logic [USE_LANES-1:0][bcg_pkg::IDX_W-1:0]      p3_q2,
    input  logic [USE_LANES-1:0][LANE_W-1:0]              p3_lane,
    output bcg_pkg::meta_t                                res_meta,
    output logic [bcg_pkg::SAMPLE_W*bcg_pkg::OUT_LANES-1:0] res_iq
);
    import bcg_pkg::*;

    localparam int IQ_W = SAMPLE_W * STORE_LANES;

    logic                                wr_en;
    meta_t                               p5_meta_reg;
    logic [IQ_W-1:0]                     wdata_reg;
    wire  [USE_LANES-1:0][SAMPLE_W-1:0]  sample;

    assign wr_en = p3_meta.valid;

    // Item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_meta_reg <= '0;
        else
            p5_meta_reg <= p3_meta;
    end

    // Forward copy of the word being written
    always_ff @(posedge clk)
    begin
        wdata_reg <= p3_iq;
    end

    // One cache copy and lane select per output lane
    for (genvar i = 0; i < USE_LANES; i++)
    begin : g_lane
        logic [IQ_W-1:0]     cache_mem [GROUPS];
        logic [GRP_W-1:0]    grp;
        logic [IQ_W-1:0]     rdata_reg;
        logic                fwd_reg;
        logic [LANE_W-1:0]   lane_reg;
        logic [IQ_W-1:0]     word;
        logic [SAMPLE_W-1:0] lane_sample;

        // quotient modulo GROUPS gives the cache word
        always_comb
        begin
            grp = GRP_W'(quot_rem(p3_q[i], p3_q2[i], DIV_W'(GROUPS)));
        end

        always_ff @(posedge clk)
        begin
            if (clr.active)
                cache_mem[clr.addr[GRP_W-1:0]] <= '0;
            else if (wr_en)
                cache_mem[p3_slot] <= p3_iq;
            rdata_reg <= cache_mem[grp];
            fwd_reg   <= wr_en && (p3_slot == grp);
            lane_reg  <= p3_lane[i];
        end

        // lanes with no input field read as zero
        always_comb
        begin
            word        = fwd_reg ? wdata_reg : rdata_reg;
            lane_sample = '0;
            for (int j = 0; j < STORE_LANES; j++)
            begin
                if (lane_reg == LANE_W'(j))
                    lane_sample = word[j*SAMPLE_W +: SAMPLE_W];
            end
        end

        assign sample[i] = lane_sample;
    end

    // Pack result lanes; unused lanes are zero
    for (genvar k = 0; k < OUT_LANES; k++)
    begin : g_out
        if (k < USE_LANES)
        begin : g_used
            assign res_iq[k*SAMPLE_W +: SAMPLE_W] = sample[k];
        end
        else
        begin : g_zero
            assign res_iq[k*SAMPLE_W +: SAMPLE_W] = '0;
        end
    end

    assign res_meta = p5_meta_reg;

endmodule

`default_nettype wire

// ===== src/bcg_out_fifo.sv =====
// ---------------------------------------------------------------------------
// bcg_out_fifo
// Result queue in front of the output channel; absorbs results still in
// the pipeline when the sink stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcg_out_fifo (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  bcg_pkg::meta_t                                push_meta,
    input  logic [bcg_pkg::SAMPLE_W*bcg_pkg::OUT_LANES-1:0] push_iq,
    output logic                                          pop,
    bcg_out_if.source                                     out_ch
);
    import bcg_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int ENT_W = SAMPLE_W * OUT_LANES + 1 + GRP_NUM_W;

    logic [ENT_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic [ENT_W-1:0] head;

    assign push = push_meta.valid;
    assign pop  = out_ch.valid && out_ch.ready;

    // Occupancy
    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= {push_meta.frame_end, push_meta.group_number, push_iq};
    end

    // Head of queue to the channel
    assign head                = fifo_mem[rd_ptr_reg];
    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.res_iq_0     = head[0*SAMPLE_W +: SAMPLE_W];
    assign out_ch.res_iq_1     = head[1*SAMPLE_W +: SAMPLE_W];
    assign out_ch.res_iq_2     = head[2*SAMPLE_W +: SAMPLE_W];
    assign out_ch.res_iq_3     = head[3*SAMPLE_W +: SAMPLE_W];
    assign out_ch.group_number = head[SAMPLE_W*OUT_LANES +: GRP_NUM_W];
    assign out_ch.frame_end    = head[ENT_W-1];

    // Checks
    `BCG_NEVER(a_no_overflow, push && !pop && count_reg == CNT_W'(FIFO_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

// ===== src/bin_to_channel_gather_unit.sv =====
// ---------------------------------------------------------------------------
// bin_to_channel_gather_unit
// Caches filter-bank bin words and gathers one channel sample per output
// lane from the cache, as listed by the channel map.
// ---------------------------------------------------------------------------
//
//  channel  dir  payload                                        role
//  in_ch    in   action, bin_iq_0..3, frame_last,               bin words and
//                map_group, map_entry                           map writes
//  out_ch   out  res_iq_0..3, frame_end, group_number           one per bin word
//
//  One item per cycle while ready is high; each bin word passes the input
//  registers, map read, two index multiply stages, cache read and queue.
//  After reset both memories are cleared, one entry a cycle, with ready low.
//  ready drops while eight results are outstanding (in flight or queued),
//  so a stalled sink holds at most the queue depth.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bin_to_channel_gather_unit #(
    parameter int BINS_PER_CLOCK = bcg_pkg::DEF_BINS_PER_CLOCK,
    parameter int RES_PER_CLOCK  = bcg_pkg::DEF_RES_PER_CLOCK,
    parameter int GROUPS         = bcg_pkg::DEF_GROUPS
) (
    input  logic       clk,
    input  logic       rst_n,
    bcg_in_if.sink     in_ch,
    bcg_out_if.source  out_ch
);
    import bcg_pkg::*;

    localparam int STORE_LANES = (BINS_PER_CLOCK < IN_LANES) ? BINS_PER_CLOCK : IN_LANES;
    localparam int USE_LANES   = (RES_PER_CLOCK < OUT_LANES) ? RES_PER_CLOCK : OUT_LANES;
    localparam int LANE_W      = (BINS_PER_CLOCK > 1) ? $clog2(BINS_PER_CLOCK) : 1;
    localparam int GRP_W       = $clog2(GROUPS);
    localparam int IQ_W        = SAMPLE_W * STORE_LANES;
    localparam int PEND_W      = $clog2(FIFO_DEPTH + 1);

    clr_t                              clr_reg, clr_next;
    logic [PEND_W-1:0]                 pend_reg, pend_next;
    logic                              accept_ok;
    logic                              accept_bin;
    logic                              pop;

    meta_t                             p1_meta, p3_meta, res_meta;
    logic [IQ_W-1:0]                   p1_iq, p3_iq;
    logic [GRP_W-1:0]                  p1_slot, p3_slot;
    logic [MAP_W-1:0]                  map_rdata;
    logic [USE_LANES-1:0][IDX_W-1:0]   p3_q, p3_q2;
    logic [USE_LANES-1:0][LANE_W-1:0]  p3_lane;
    logic [SAMPLE_W*OUT_LANES-1:0]     res_iq;

    // Clearing sweep and outstanding-result credit
    always_comb
    begin
        clr_next = clr_reg;
        if (clr_reg.active)
        begin
            clr_next.addr = clr_reg.addr + 1'b1;
            if (clr_reg.addr == MAX_GRP_W'(GROUPS - 1))
                clr_next.active = 1'b0;
        end
        pend_next = pend_reg + PEND_W'(accept_bin) - PEND_W'(pop);
        accept_ok = !clr_reg.active && (pend_reg < PEND_W'(FIFO_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg.active <= 1'b1;
            clr_reg.addr   <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            clr_reg  <= clr_next;
            pend_reg <= pend_next;
        end
    end

    // Pipeline
    bcg_map_stage #(
        .BINS_PER_CLOCK (BINS_PER_CLOCK),
        .GROUPS         (GROUPS)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .accept_ok  (accept_ok),
        .clr        (clr_reg),
        .accept_bin (accept_bin),
        .p1_meta    (p1_meta),
        .p1_iq      (p1_iq),
        .p1_slot    (p1_slot),
        .map_rdata  (map_rdata)
    );

    bcg_index_calc #(
        .BINS_PER_CLOCK (BINS_PER_CLOCK),
        .RES_PER_CLOCK  (RES_PER_CLOCK),
        .GROUPS         (GROUPS)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .p1_meta   (p1_meta),
        .p1_iq     (p1_iq),
        .p1_slot   (p1_slot),
        .map_rdata (map_rdata),
        .p3_meta   (p3_meta),
        .p3_iq     (p3_iq),
        .p3_slot   (p3_slot),
        .p3_q      (p3_q),
        .p3_q2     (p3_q2),
        .p3_lane   (p3_lane)
    );

    bcg_cache #(
        .BINS_PER_CLOCK (BINS_PER_CLOCK),
        .RES_PER_CLOCK  (RES_PER_CLOCK),
        .GROUPS         (GROUPS)
    ) u_cache (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr_reg),
        .p3_meta  (p3_meta),
        .p3_iq    (p3_iq),
        .p3_slot  (p3_slot),
        .p3_q     (p3_q),
        .p3_q2    (p3_q2),
        .p3_lane  (p3_lane),
        .res_meta (res_meta),
        .res_iq   (res_iq)
    );

    bcg_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_meta (res_meta),
        .push_iq   (res_iq),
        .pop       (pop),
        .out_ch    (out_ch)
    );

    // Checks
    `BCG_ASSERT(a_pend_bound, pend_reg <= PEND_W'(FIFO_DEPTH), "outstanding results exceed queue depth")
    `BCG_NEVER(a_pop_without_credit, pop && pend_reg == '0, "result delivered with nothing outstanding")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: bin to channel gather unit testbench
// Feeds bin words and channel map writes, predicts every gathered channel
// word from a local copy of the bin cache, map and counters, and checks each
// result in order under a range of source idling and sink stalling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bcg_pkg::*;

    localparam int BPC          = DEF_BINS_PER_CLOCK;
    localparam int RPC          = DEF_RES_PER_CLOCK;
    localparam int GROUPS       = DEF_GROUPS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_REPORTS  = 10;

    // One input item: a bin word or a map write
    typedef struct {
        action_t                           action;
        logic [IN_LANES-1:0][SAMPLE_W-1:0] iq;
        logic                              frame_last;
        logic [GRP_NUM_W-1:0]              map_group;
        logic [MAP_W-1:0]                  map_entry;
    } feed_item_t;

    // One gathered channel word
    typedef struct {
        logic [OUT_LANES-1:0][SAMPLE_W-1:0] iq;
        logic                               frame_end;
        logic [GRP_NUM_W-1:0]               group_number;
    } chan_word_t;

    logic clk;
    logic rst_n;

    bcg_in_if  in_ch ();
    bcg_out_if out_ch ();

    bin_to_channel_gather_unit #(
        .BINS_PER_CLOCK (BPC),
        .RES_PER_CLOCK  (RPC),
        .GROUPS         (GROUPS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Local copy of the block state
    logic [IN_LANES-1:0][SAMPLE_W-1:0] bin_store [GROUPS];
    logic [MAP_W-1:0]                  chan_map  [GROUPS];
    int                                replay_grp;
    int                                write_slot;
    chan_word_t                        pending_chan_q [$];

    // Run control and statistics
    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold_req;
    int sink_hold_cnt;
    int frame_left;
    int cycle_cnt;
    int mismatch_cnt;
    int checked_cnt;
    int bin_cnt;
    int map_writes;
    int replay_wraps;
    int slot_wraps;
    int max_in_stall;

    // Clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_chan_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sink ready: random stalls, plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (sink_hold_req > 0)
        begin
            sink_hold_cnt = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_hold_cnt > 0)
        begin
            sink_hold_cnt--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Work out the result of one accepted item and update the local state
    function automatic void predict_gather(input feed_item_t it);
        chan_word_t       w;
        logic [MAP_W-1:0] entry;
        logic [IDX_W-1:0] idx;
        int               lane;

        if (it.action == ACT_MAP)
        begin
            chan_map[it.map_group % GROUPS] = it.map_entry;
            map_writes++;
            return;
        end

        // cache write first, so the lookup sees this word
        for (int i = 0; i < IN_LANES; i++)
            if (i < BPC)
                bin_store[write_slot][i] = it.iq[i];

        entry = chan_map[replay_grp];
        for (int i = 0; i < OUT_LANES; i++)
        begin
            w.iq[i] = '0;
            if (i < RPC)
            begin
                idx  = entry[IDX_W*i +: IDX_W];
                lane = idx % BPC;
                if (lane < IN_LANES)
                    w.iq[i] = bin_store[(idx / BPC) % GROUPS][lane];
            end
        end
        w.frame_end    = (replay_grp == GROUPS - 1);
        w.group_number = GRP_NUM_W'(replay_grp);
        pending_chan_q.push_back(w);
        bin_cnt++;

        replay_grp = (replay_grp + 1) % GROUPS;
        if (replay_grp == 0)
            replay_wraps++;
        if (it.frame_last)
            write_slot = 0;
        else
        begin
            write_slot = (write_slot + 1) % GROUPS;
            if (write_slot == 0)
                slot_wraps++;
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    task automatic check_chan_word();
        chan_word_t want;
        chan_word_t got;

        got.iq[0]        = out_ch.res_iq_0;
        got.iq[1]        = out_ch.res_iq_1;
        got.iq[2]        = out_ch.res_iq_2;
        got.iq[3]        = out_ch.res_iq_3;
        got.frame_end    = out_ch.frame_end;
        got.group_number = out_ch.group_number;

        if (pending_chan_q.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("[%0t] ERROR: unexpected result grp=%0d end=%b iq=%h",
                         $time, got.group_number, got.frame_end, got.iq);
            return;
        end

        want = pending_chan_q.pop_front();
        checked_cnt++;
        if (got.iq !== want.iq || got.frame_end !== want.frame_end ||
            got.group_number !== want.group_number)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
            begin
                $display("[%0t] ERROR: result mismatch", $time);
                $display("    expected grp=%0d end=%b iq=%h",
                         want.group_number, want.frame_end, want.iq);
                $display("    actual   grp=%0d end=%b iq=%h",
                         got.group_number, got.frame_end, got.iq);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_chan_word();
    end

    // Offer one item from a falling edge; returns at the falling edge after it
    // has been taken
    task automatic push_feed(input feed_item_t it);
        int stall;

        stall = 0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= it.action;
        in_ch.bin_iq_0   <= it.iq[0];
        in_ch.bin_iq_1   <= it.iq[1];
        in_ch.bin_iq_2   <= it.iq[2];
        in_ch.bin_iq_3   <= it.iq[3];
        in_ch.frame_last <= it.frame_last;
        in_ch.map_group  <= it.map_group;
        in_ch.map_entry  <= it.map_entry;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            stall++;
            @(posedge clk);
        end
        if (stall > max_in_stall)
            max_in_stall = stall;
        predict_gather(it);
        @(negedge clk);
    endtask

    function automatic logic [MAP_W-1:0] pack_idx(input int a, input int b,
                                                  input int c, input int d);
        return {IDX_W'(d), IDX_W'(c), IDX_W'(b), IDX_W'(a)};
    endfunction

    // Map write; bin fields carry junk that must be ignored
    function automatic feed_item_t map_feed(input int grp, input logic [MAP_W-1:0] entry);
        feed_item_t it;

        it.action     = ACT_MAP;
        it.iq         = {$urandom(), $urandom(), $urandom(), $urandom()};
        it.frame_last = 1'($urandom_range(1));
        it.map_group  = GRP_NUM_W'(grp);
        it.map_entry  = entry;
        return it;
    endfunction

    // Bin word; map fields carry junk that must be ignored
    function automatic feed_item_t bin_feed(input logic [SAMPLE_W-1:0] q0,
                                            input logic [SAMPLE_W-1:0] q1,
                                            input logic [SAMPLE_W-1:0] q2,
                                            input logic [SAMPLE_W-1:0] q3,
                                            input logic last);
        feed_item_t it;

        it.action     = ACT_BIN;
        it.iq         = {q3, q2, q1, q0};
        it.frame_last = last;
        it.map_group  = GRP_NUM_W'($urandom());
        it.map_entry  = MAP_W'({$urandom(), $urandom()});
        return it;
    endfunction

    // Random item: mostly bin words in frames, some map writes, rare early ends
    function automatic feed_item_t random_feed();
        feed_item_t       it;
        logic [MAP_W-1:0] entry;
        int               idx;

        if ($urandom_range(99) < 10)
        begin
            for (int i = 0; i < OUT_LANES; i++)
            begin
                case ($urandom_range(3))
                    0:       idx = $urandom_range(4095);
                    1:       idx = $urandom_range(1) ? 4095 : 0;
                    // recent or about-to-be-written cache words
                    default: idx = ((write_slot + GROUPS - $urandom_range(4)) % GROUPS) * BPC
                                   + $urandom_range(BPC - 1);
                endcase
                entry[IDX_W*i +: IDX_W] = IDX_W'(idx);
            end
            // often aim at the next replayed group so the entry is used soon
            if ($urandom_range(3) == 0)
                return map_feed((replay_grp + $urandom_range(2)) % GROUPS, entry);
            return map_feed($urandom_range(GROUPS - 1), entry);
        end

        it = bin_feed($urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        for (int i = 0; i < IN_LANES; i++)
            if ($urandom_range(7) == 0)
                it.iq[i] = $urandom_range(1) ? '1 : '0;

        frame_left--;
        it.frame_last = (frame_left <= 0) ||
                        (frame_left <= 64 && $urandom_range(99) == 0);
        if (it.frame_last)
            frame_left = ($urandom_range(9) == 0) ? $urandom_range(65, 300)
                                                   : $urandom_range(1, 48);
        return it;
    endfunction

    // Directed: same-step lookup, map extremes, frame ends, ignored fields
    task automatic test_directed_cases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // empty map points every lane at the word being written
        push_feed(bin_feed(32'hA5A5_5A5A, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 1'b0));
        push_feed(map_feed(1, pack_idx(4, 5, 6, 7)));
        push_feed(map_feed(2, pack_idx(3, 2, 1, 0)));
        push_feed(map_feed(3, '1));
        push_feed(map_feed(4, pack_idx(4095, 0, 2048, 5)));
        push_feed(map_feed(5, pack_idx(0, 1, 2, 3)));
        push_feed(map_feed(GROUPS - 1, pack_idx(0, 4, 8, 4092)));
        push_feed(bin_feed(32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
                           32'h4444_4444, 1'b0));
        push_feed(bin_feed('1, '1, '1, '1, 1'b1));
        push_feed(bin_feed('0, '0, '0, '0, 1'b0));
        push_feed(bin_feed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                           32'hFFFF_FFFE, 1'b1));
        push_feed(bin_feed($urandom(), $urandom(), $urandom(), $urandom(), 1'b0));
        push_feed(map_feed(0, '0));
        push_feed(map_feed(6, pack_idx(4092, 4093, 4094, 4095)));
        push_feed(bin_feed($urandom(), $urandom(), $urandom(), $urandom(), 1'b0));
    endtask

    // Sink holds off for a long stretch while the source keeps offering
    task automatic test_input_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = HOLD_CYCLES;
        repeat (60)
            push_feed(random_feed());
    endtask

    task automatic test_random_stream(input int n, input int src_idle, input int sink_stall);
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        repeat (n)
            push_feed(random_feed());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_BIN;
        in_ch.bin_iq_0   = '0;
        in_ch.bin_iq_1   = '0;
        in_ch.bin_iq_2   = '0;
        in_ch.bin_iq_3   = '0;
        in_ch.frame_last = 1'b0;
        in_ch.map_group  = '0;
        in_ch.map_entry  = '0;
        out_ch.ready     = 1'b0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_req    = 0;
        sink_hold_cnt    = 0;
        cycle_cnt        = 0;
        mismatch_cnt     = 0;
        checked_cnt      = 0;
        bin_cnt          = 0;
        map_writes       = 0;
        replay_wraps     = 0;
        slot_wraps       = 0;
        max_in_stall     = 0;
        replay_grp       = 0;
        write_slot       = 0;
        foreach (bin_store[g])
            bin_store[g] = '0;
        foreach (chan_map[g])
            chan_map[g] = '0;
        // first random frame length
        frame_left = $urandom_range(1, 48);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_input_stall();
        test_random_stream(275, 0, 0);
        test_random_stream(200, 81, 0);
        test_random_stream(200, 0, 81);
        test_random_stream(200, 25, 25);

        // drain
        in_ch.valid    <= 1'b0;
        sink_stall_pct = 0;
        while (pending_chan_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bin words and %0d map writes, checked %0d channel words",
                 bin_cnt, map_writes, checked_cnt);
        $display("Replay wraps %0d, write slot wraps %0d, longest input stall %0d cycles",
                 replay_wraps, slot_wraps, max_in_stall);
        if (mismatch_cnt == 0 && pending_chan_q.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_cnt, pending_chan_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/bcg_pkg.sv
src/bcg_in_if.sv
src/bcg_out_if.sv
src/bcg_map_stage.sv
src/bcg_index_calc.sv
src/bcg_cache.sv
src/bcg_out_fifo.sv
src/bin_to_channel_gather_unit.sv
bench/tb.sv
